// ===== rtl/core/sgm_pkg.sv =====
// shared types and constants for the sobel gradient magnitude block
// no dependencies; imported by sobel_gradient_magnitude
`default_nettype none

package sgm_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIX_W  = 8;
   localparam int FW_W   = 11;
   localparam int FH_W   = 13;
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 13;

   // widest row the width register can select
   localparam int EFF_W_MAX  = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
   localparam int EW_W       = $clog2(EFF_W_MAX + 1);
   localparam int COL_W      = $clog2(EFF_W_MAX);
   localparam int LINE_DEPTH = EFF_W_MAX;
   localparam int DRAIN_W    = $clog2(EFF_W_MAX + 2);
   localparam int EH_W       = $clog2(MAX_HEIGHT + 1);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   localparam int GRAD_W = 11;
   localparam int SUM_W  = 21;
   localparam int ROOT_W = 22;
   localparam int PROD_W = 2 * GRAD_W;

   localparam logic [CSR_IW-1:0] CSR_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_CLIP_NEGATIVE = 2'd2;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   localparam logic [0:0] MODE_PIXEL = 1'b0;
   localparam logic [0:0] MODE_DRAIN = 1'b1;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_LOAD   = 8'b0000_0010,
      ST_GRAD   = 8'b0000_0100,
      ST_SQX    = 8'b0000_1000,
      ST_SQY    = 8'b0001_0000,
      ST_ROOT   = 8'b0010_0000,
      ST_ROUND  = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/sobel_gradient_magnitude.sv =====
// sobel gradient magnitude over a raster-order 8-bit grayscale stream
// uses sgm_pkg; holds both line buffers as internal synchronous memories
//
// One pixel is taken at a time. A pixel transfer occupies the block through the accept
// cycle (line buffer read), the window update and write back, the gradient, squaring
// of both gradients on one shared multiplier, 11 steps of the bit-serial square root,
// rounding and the hand-off to the output register. req_stall is low only while the
// block is free. A result waits in the output register and does not keep the next
// pixel out, but the hand-off of a later result waits while it is still stalled. The
// line buffers are not cleared after reset; their first reads only feed border
// outputs, which are zero. The user must write the frame size and clip mode through the
// csr_ port only while no pixel is in flight; the block does not enforce this.
`default_nettype none

module sobel_gradient_magnitude (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_mode,
   input  wire logic [sgm_pkg::PIX_W-1:0]  req_pixel,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [sgm_pkg::PIX_W-1:0]       rsp_magnitude,
   output logic                            rsp_last_of_frame,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [sgm_pkg::CSR_IW-1:0] csr_index,
   input  wire logic [sgm_pkg::CSR_DW-1:0] csr_data
);
   import sgm_pkg::*;

   // configuration
   logic [FW_W-1:0] frame_width_ff;
   logic [FH_W-1:0] frame_height_ff;
   logic            clip_negative_ff;

   // control
   state_type         state_ff, state_in;
   logic [COL_W-1:0]  column_count_ff, column_count_in;
   logic [ROW_W-1:0]  row_count_ff, row_count_in;
   logic [DRAIN_W-1:0] drain_count_ff, drain_count_in;
   logic [20:0]       bit_ff, bit_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   logic [PIX_W-1:0]  pix_ff, pix_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic              res_emit_ff, res_emit_in;
   logic              res_last_ff, res_last_in;
   logic              border_ff, border_in;
   logic [PIX_W-1:0]  res_mag_ff, res_mag_in;
   logic signed [GRAD_W-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [PIX_W-1:0]  rsp_mag_ff, rsp_mag_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [PIX_W-1:0]  win_ff [0:8];
   logic [PIX_W-1:0]  win_in [0:8];

   // line buffers
   logic [PIX_W-1:0]  line_one_above [0:LINE_DEPTH-1];
   logic [PIX_W-1:0]  line_two_above [0:LINE_DEPTH-1];
   logic [PIX_W-1:0]  rd_one_ff, rd_two_ff;
   logic [COL_W-1:0]  rd_addr;
   logic              rd_en, wr_en;

   logic              accept;
   logic [EW_W-1:0]   eff_w, w_m1, col_e, col_sel, out_c;
   logic [EH_W-1:0]   eff_h, h_m1, row_e, row_sel, out_r;
   logic              emit, border;
   logic signed [GRAD_W-1:0] g_sel;
   logic signed [PROD_W-1:0] prod;
   logic [SUM_W-1:0]  sq;
   logic [ROOT_W:0]   trial;
   logic [ROOT_W-1:0] root_rnd;
   logic              out_free;

   assign req_stall         = (state_ff != ST_IDLE);
   assign accept            = req_valid && !req_stall;
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_magnitude     = rsp_mag_ff;
   assign rsp_last_of_frame = rsp_last_ff;
   assign out_free          = !rsp_valid_ff || !rsp_stall;

   // effective frame size and position of the incoming pixel
   always_comb begin
      if (frame_width_ff < FW_W'(3)) begin
         eff_w = EW_W'(3);
      end else if (32'(frame_width_ff) > EFF_W_MAX) begin
         eff_w = EW_W'(EFF_W_MAX);
      end else begin
         eff_w = EW_W'(frame_width_ff);
      end
      if (frame_height_ff < FH_W'(3)) begin
         eff_h = EH_W'(3);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         eff_h = EH_W'(MAX_HEIGHT);
      end else begin
         eff_h = EH_W'(frame_height_ff);
      end
      w_m1    = eff_w - EW_W'(1);
      h_m1    = eff_h - EH_W'(1);
      col_e   = EW_W'(column_count_ff);
      row_e   = EH_W'(row_count_ff);
      col_sel = (col_e >= eff_w) ? w_m1 : col_e;
      row_sel = (row_e >= eff_h) ? h_m1 : row_e;
      emit    = (row_sel >= EH_W'(2)) || (row_sel == EH_W'(1) && col_sel != EW_W'(0));
      if (col_sel == EW_W'(0)) begin
         out_r = (row_sel >= EH_W'(2)) ? row_sel - EH_W'(2) : EH_W'(0);
         out_c = w_m1;
      end else begin
         out_r = row_sel - EH_W'(1);
         out_c = col_sel - EW_W'(1);
      end
      border = (out_r == EH_W'(0)) || (out_r >= h_m1) ||
               (out_c == EW_W'(0)) || (out_c >= w_m1);
   end

   assign rd_addr = col_sel[COL_W-1:0];
   assign rd_en   = accept && (req_mode == MODE_PIXEL);
   assign wr_en   = (state_ff == ST_LOAD);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_one_ff <= line_one_above[rd_addr];
      end
      if (wr_en) begin
         line_one_above[col_ff] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_two_ff <= line_two_above[rd_addr];
      end
      if (wr_en) begin
         line_two_above[col_ff] <= rd_one_ff;
      end
   end

   // one squaring multiplier shared by both gradients
   assign g_sel = (state_ff == ST_SQX) ? gx_ff : gy_ff;
   assign prod  = g_sel * g_sel;
   assign sq    = prod[SUM_W-1:0];
   assign trial = {1'b0, root_ff} + (ROOT_W + 1)'(bit_ff);

   always_comb begin
      logic [PIX_W+2:0] px, nx, py, ny;
      logic signed [GRAD_W:0] gx_raw, gy_raw;
      px = 11'(win_ff[2]) + {2'b0, win_ff[5], 1'b0} + 11'(win_ff[8]);
      nx = 11'(win_ff[0]) + {2'b0, win_ff[3], 1'b0} + 11'(win_ff[6]);
      py = 11'(win_ff[6]) + {2'b0, win_ff[7], 1'b0} + 11'(win_ff[8]);
      ny = 11'(win_ff[0]) + {2'b0, win_ff[1], 1'b0} + 11'(win_ff[2]);
      gx_raw = $signed({1'b0, px}) - $signed({1'b0, nx});
      gy_raw = $signed({1'b0, py}) - $signed({1'b0, ny});
      if (clip_negative_ff && gx_raw < 0) begin
         gx_raw = '0;
      end else if (clip_negative_ff && gx_raw > 255) begin
         gx_raw = 12'sd255;
      end
      if (clip_negative_ff && gy_raw < 0) begin
         gy_raw = '0;
      end else if (clip_negative_ff && gy_raw > 255) begin
         gy_raw = 12'sd255;
      end

      state_in        = state_ff;
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      drain_count_in  = drain_count_ff;
      bit_in          = bit_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      pix_in          = pix_ff;
      col_in          = col_ff;
      res_emit_in     = res_emit_ff;
      res_last_in     = res_last_ff;
      border_in       = border_ff;
      res_mag_in      = res_mag_ff;
      gx_in           = gx_ff;
      gy_in           = gy_ff;
      sum_in          = sum_ff;
      rem_in          = rem_ff;
      root_in         = root_ff;
      rsp_mag_in      = rsp_mag_ff;
      rsp_last_in     = rsp_last_ff;
      win_in          = win_ff;
      root_rnd        = (rem_ff > SUM_W'(root_ff)) ? root_ff + ROOT_W'(1) : root_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode == MODE_DRAIN) begin
               res_mag_in  = '0;
               res_emit_in = (drain_count_ff != '0);
               res_last_in = (drain_count_ff == DRAIN_W'(1));
               if (drain_count_ff != '0) begin
                  drain_count_in = drain_count_ff - DRAIN_W'(1);
               end
               state_in = ST_FINISH;
            end else if (accept) begin
               pix_in         = req_pixel;
               col_in         = col_sel[COL_W-1:0];
               res_emit_in    = emit;
               res_last_in    = 1'b0;
               border_in      = border;
               drain_count_in = '0;
               if (col_sel >= w_m1) begin
                  column_count_in = '0;
                  if (row_sel >= h_m1) begin
                     row_count_in   = '0;
                     drain_count_in = DRAIN_W'(eff_w) + DRAIN_W'(1);
                  end else begin
                     row_count_in = row_sel[ROW_W-1:0] + ROW_W'(1);
                  end
               end else begin
                  column_count_in = col_sel[COL_W-1:0] + COL_W'(1);
                  row_count_in    = row_sel[ROW_W-1:0];
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            win_in[0] = win_ff[1];
            win_in[1] = win_ff[2];
            win_in[2] = rd_two_ff;
            win_in[3] = win_ff[4];
            win_in[4] = win_ff[5];
            win_in[5] = rd_one_ff;
            win_in[6] = win_ff[7];
            win_in[7] = win_ff[8];
            win_in[8] = pix_ff;
            state_in  = ST_GRAD;
         end
         ST_GRAD: begin
            gx_in    = gx_raw[GRAD_W-1:0];
            gy_in    = gy_raw[GRAD_W-1:0];
            state_in = ST_SQX;
         end
         ST_SQX: begin
            sum_in   = sq;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            rem_in   = sum_ff + sq;
            root_in  = '0;
            bit_in   = 21'h10_0000;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if ((ROOT_W + 1)'(rem_ff) >= trial) begin
               rem_in  = rem_ff - trial[SUM_W-1:0];
               root_in = (root_ff >> 1) + ROOT_W'(bit_ff);
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (border_ff) begin
               res_mag_in = '0;
            end else if (root_rnd > ROOT_W'(255)) begin
               res_mag_in = 8'd255;
            end else begin
               res_mag_in = root_rnd[PIX_W-1:0];
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!res_emit_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mag_in   = res_mag_ff;
               rsp_last_in  = res_last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         column_count_ff <= '0;
         row_count_ff    <= '0;
         drain_count_ff  <= '0;
         bit_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         drain_count_ff  <= drain_count_in;
         bit_ff          <= bit_in;
         rsp_valid_ff    <= rsp_valid_in;
         win_ff          <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      col_ff      <= col_in;
      res_emit_ff <= res_emit_in;
      res_last_ff <= res_last_in;
      border_ff   <= border_in;
      res_mag_ff  <= res_mag_in;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      sum_ff      <= sum_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      rsp_mag_ff  <= rsp_mag_in;
      rsp_last_ff <= rsp_last_in;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= FRAME_WIDTH_RESET;
         frame_height_ff  <= FRAME_HEIGHT_RESET;
         clip_negative_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH:   frame_width_ff   <= csr_data[FW_W-1:0];
            CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_data[FH_W-1:0];
            CSR_CLIP_NEGATIVE: clip_negative_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // a pixel transfer always goes on to the line buffer update
   a_pixel_loads: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_PIXEL) |=> state_ff == ST_LOAD)
      else $error("pixel transfer did not enter load");

   // the end-of-frame marker only rides on a zero drain output
   a_last_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> rsp_mag_ff == '0)
      else $error("last of frame with nonzero magnitude");

   // the root of a sum of two squared gradients stays within 11 bits
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> root_ff[ROOT_W-1:11] == '0)
      else $error("square root out of range");

   // a drain tick with nothing owed makes no result
   a_idle_drain: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_DRAIN && drain_count_ff == '0 && !rsp_valid_ff)
      |=> !rsp_valid_ff)
      else $error("result from an empty drain");

endmodule

`default_nettype wire
